// File: rtl/dec_pkg.sv
// Shared types and constants for the debounced event chronometer.
// Used by dec_core, dec_frame_fifo and the top level; depends on nothing.
package dec_pkg;

  // Input item kinds
  localparam logic [2:0] KIND_COUNT  = 3'd0;
  localparam logic [2:0] KIND_TICK   = 3'd1;
  localparam logic [2:0] KIND_PIN    = 3'd2;
  localparam logic [2:0] KIND_SERIAL = 3'd3;
  localparam logic [2:0] KIND_ENC    = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_DEBOUNCE   = 3'd1;
  localparam logic [2:0] REG_STATUS_CMD = 3'd2;
  localparam logic [2:0] REG_STATUS_REP = 3'd3;
  localparam logic [2:0] REG_HEADER     = 3'd4;
  localparam logic [2:0] REG_SCAN_CMD   = 3'd5;

  // Operating modes
  localparam logic MODE_CHRONO  = 1'b0;
  localparam logic MODE_ENCODER = 1'b1;

  // Register reset values
  localparam logic [7:0] RST_DEBOUNCE   = 8'h14;
  localparam logic [7:0] RST_STATUS_CMD = 8'h45;
  localparam logic [7:0] RST_STATUS_REP = 8'h45;
  localparam logic [7:0] RST_HEADER     = 8'h58;
  localparam logic [7:0] RST_SCAN_CMD   = 8'h4A;

  localparam logic [7:0] TOP_SAT = 8'hFF;

  // Frame queue geometry
  localparam int FRAME_BYTES = 5;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = 2;

  typedef struct packed {
    logic [2:0]                        len;   // bytes in frame, 1 to 5
    logic [FRAME_BYTES-1:0][7:0]       bytes; // byte 0 goes out first
  } frame_t;

endpackage

// File: rtl/dec_core.sv
// Configuration registers, chronometer / encoder state and frame builder.
// Depends on dec_pkg; produces one frame per accepted item at most.
module dec_core
  import dec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       accept,
  input  logic [2:0] kind,
  input  logic       pin_level,
  input  logic [7:0] rx_byte,
  input  logic       direction,
  output logic       push,
  output frame_t     frame
);

  logic       mode;
  logic [7:0] debounce_ticks, status_command, status_reply, change_header, scan_command;

  logic [23:0] elapsed, elapsed_next;
  logic [23:0] captured_time, captured_time_next;
  logic [7:0]  debounce_left, debounce_left_next;
  logic        debouncing, debouncing_next;
  logic        stable_level, stable_level_next;
  logic        first_pending, first_pending_next;
  logic [7:0]  pulse_count, pulse_count_next;

  logic [7:0]  left_dec;
  logic        lvl;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_ENCODER;
      debounce_ticks <= RST_DEBOUNCE;
      status_command <= RST_STATUS_CMD;
      status_reply   <= RST_STATUS_REP;
      change_header  <= RST_HEADER;
      scan_command   <= RST_SCAN_CMD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:       mode           <= cfg_data[0];
        REG_DEBOUNCE:   debounce_ticks <= cfg_data;
        REG_STATUS_CMD: status_command <= cfg_data;
        REG_STATUS_REP: status_reply   <= cfg_data;
        REG_HEADER:     change_header  <= cfg_data;
        REG_SCAN_CMD:   scan_command   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    elapsed_next       = elapsed;
    captured_time_next = captured_time;
    debounce_left_next = debounce_left;
    debouncing_next    = debouncing;
    stable_level_next  = stable_level;
    first_pending_next = first_pending;
    pulse_count_next   = pulse_count;
    push               = 1'b0;
    frame              = '0;
    left_dec           = (debounce_left != 8'd0) ? debounce_left - 8'd1 : debounce_left;
    lvl                = ~pin_level;

    if (mode == MODE_CHRONO) begin
      unique case (kind)
        KIND_COUNT: begin
          if (elapsed[15:0] == 16'hFFFF) begin
            elapsed_next[15:0] = 16'h0000;
            // top byte sticks at full scale
            if (elapsed[23:16] != TOP_SAT) elapsed_next[23:16] = elapsed[23:16] + 8'd1;
          end else begin
            elapsed_next[15:0] = elapsed[15:0] + 16'd1;
          end
        end
        KIND_TICK: begin
          debounce_left_next = left_dec;
          if (debouncing && left_dec == 8'd0) begin
            debouncing_next = 1'b0;
            if (lvl == stable_level) begin
              // spurious change: give the captured time back to the timer
              elapsed_next = elapsed + captured_time;
            end else begin
              stable_level_next = lvl;
              push              = 1'b1;
              frame.len         = 3'd5;
              frame.bytes[0]    = change_header;
              frame.bytes[1]    = {7'd0, lvl};
              frame.bytes[2]    = captured_time[23:16];
              frame.bytes[3]    = captured_time[15:8];
              frame.bytes[4]    = captured_time[7:0];
            end
          end
        end
        KIND_PIN: begin
          if (!debouncing) begin
            captured_time_next = first_pending ? 24'd0 : elapsed;
            first_pending_next = 1'b0;
            elapsed_next       = 24'd0;
            debounce_left_next = debounce_ticks;
            debouncing_next    = 1'b1;
          end
        end
        KIND_SERIAL: begin
          if (rx_byte == status_command) begin
            push           = 1'b1;
            frame.len      = 3'd2;
            frame.bytes[0] = status_reply;
            frame.bytes[1] = {7'd0, stable_level};
          end
        end
        default: ;
      endcase
    end else begin
      unique case (kind)
        KIND_TICK: begin
          push             = 1'b1;
          frame.len        = 3'd1;
          frame.bytes[0]   = pulse_count;
          pulse_count_next = 8'd0;
        end
        KIND_SERIAL: begin
          if (rx_byte == scan_command) begin
            push           = 1'b1;
            frame.len      = 3'd1;
            frame.bytes[0] = scan_command;
          end
        end
        KIND_ENC: pulse_count_next = direction ? pulse_count + 8'd1 : pulse_count - 8'd1;
        default: ;
      endcase
    end

    push = push & accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed       <= 24'd0;
      captured_time <= 24'd0;
      debounce_left <= RST_DEBOUNCE;
      debouncing    <= 1'b0;
      stable_level  <= 1'b0;
      first_pending <= 1'b1;
      pulse_count   <= 8'd0;
    end else if (accept) begin
      elapsed       <= elapsed_next;
      captured_time <= captured_time_next;
      debounce_left <= debounce_left_next;
      debouncing    <= debouncing_next;
      stable_level  <= stable_level_next;
      first_pending <= first_pending_next;
      pulse_count   <= pulse_count_next;
    end
  end

endmodule

// File: rtl/dec_frame_fifo.sv
// Frame queue and byte serialiser: holds whole frames, sends one byte a cycle while out_ready is high.
// Depends on dec_pkg for frame_t and the queue geometry.
module dec_frame_fifo
  import dec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  frame_t     frame,
  output logic       full,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  localparam logic [FIFO_AW:0] DEPTH = (FIFO_AW+1)'(FIFO_DEPTH);

  frame_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW:0]   count;
  logic [2:0]         byte_idx;
  frame_t             head;
  logic               pop;

  assign head      = mem[rd_ptr];
  assign full      = (count == DEPTH);
  assign out_valid = (count != '0);
  assign out_byte  = head.bytes[byte_idx];
  assign out_last  = (byte_idx == head.len - 3'd1);
  assign pop       = out_valid && out_ready && out_last;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= frame;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
      byte_idx <= 3'd0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
      // advance within the frame, restart on the next one
      if (out_valid && out_ready) byte_idx <= out_last ? 3'd0 : byte_idx + 3'd1;
    end
  end

endmodule

// File: rtl/debounced_event_chronometer.sv
// Debounced event chronometer / encoder pulse counter, top level.
// Instantiates dec_core and dec_frame_fifo; depends on dec_pkg.
//
// Usage:
//   Input items arrive on s_* (kind in s_tuser, pin/rx/direction in s_tdata)
//   and are accepted when s_tvalid and s_tready are both high. Each item is
//   processed in the cycle it is accepted: one item per clock while the queue
//   has room. Result bytes leave on m_* one per cycle while m_tready is high,
//   m_tlast on the final byte of a frame (change 5 bytes, status 2, report or
//   echo 1). A frame's first byte is offered the cycle after its item is
//   accepted if the queue was empty. Frames wait in a four-frame queue;
//   s_tready drops only while that queue is full, so a stalled receiver holds
//   the input back after four frames. Items that cause no frame still need a
//   free queue slot to enter. Configuration is written through cfg_we /
//   cfg_index / cfg_data, one register per clock, while the block is idle.
//   Synchronous reset rst restores register defaults (encoder mode), clears
//   the timer, pulse counter and queue; the block accepts items the next cycle.
module debounced_event_chronometer
  import dec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // pin_level[0], rx_byte[8:1], direction[9], zero pad
  input  logic [2:0]  s_tuser,  // kind[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // tx_byte[7:0]
  output logic        m_tlast
);

  logic   accept, push, full;
  frame_t frame;

  assign s_tready = ~full;
  assign accept   = s_tvalid & s_tready;

  dec_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .kind      (s_tuser),
    .pin_level (s_tdata[0]),
    .rx_byte   (s_tdata[8:1]),
    .direction (s_tdata[9]),
    .push      (push),
    .frame     (frame)
  );

  dec_frame_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .frame     (frame),
    .full      (full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

`ifndef SYNTHESIS
  a_full_has_output: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("queue full with no output offered");

  a_reset_empties: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (!m_tvalid && s_tready))
    else $error("queue not empty after reset");

  a_frame_continues: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("frame broken before its last byte");
`endif

endmodule

// File: tb/tb_debounced_event_chronometer.sv
`timescale 1ns / 1ps
// Self-checking bench for debounced_event_chronometer: feeds sensor items on the input
// stream, predicts every transmitted byte in order and checks it on the output stream.
// Depends on dec_pkg and the block's RTL.
module tb_debounced_event_chronometer;
  import dec_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [2:0] kind;
    logic       pin;
    logic [7:0] rx;
    logic       up;
  } sense_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } tx_byte_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = REG_MODE;
  logic [7:0]  cfg_data  = 8'h00;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = 16'h0000;  // pin_level[0], rx_byte[8:1], direction[9], zero pad
  logic [2:0]  s_tuser   = KIND_COUNT; // kind[2:0]
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;                // tx_byte[7:0]
  logic        m_tlast;

  debounced_event_chronometer dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  sense_item_t events_to_send[$];
  tx_byte_t    tx_bytes_due[$];
  sense_item_t next_event;
  tx_byte_t    want;

  int err_count    = 0;
  int quiet_cycles = 0;
  int gap_left     = 0;
  int stall_left   = 0;
  int gap_pct      = 0;
  int stall_pct    = 0;
  bit calm         = 1'b0;

  // Predictor copy of the registers and of the block state
  logic        sel_mode;
  logic [7:0]  settle_ticks, status_cmd, status_rep, change_hdr, scan_cmd;
  logic [23:0] timer, stamp;
  logic [7:0]  countdown, pulses;
  logic        settling, held_level, awaiting_first;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void reset_predictor();
    sel_mode       = MODE_ENCODER;
    settle_ticks   = RST_DEBOUNCE;
    status_cmd     = RST_STATUS_CMD;
    status_rep     = RST_STATUS_REP;
    change_hdr     = RST_HEADER;
    scan_cmd       = RST_SCAN_CMD;
    timer          = '0;
    stamp          = '0;
    countdown      = RST_DEBOUNCE;
    settling       = 1'b0;
    held_level     = 1'b0;
    awaiting_first = 1'b1;
    pulses         = '0;
  endfunction

  function automatic void owe_byte(input logic [7:0] data, input logic last);
    tx_bytes_due.push_back({data, last});
  endfunction

  function automatic void compute_tx_bytes(input sense_item_t it);
    logic [15:0] low;
    logic [7:0]  top;
    logic        lvl;
    if (sel_mode == MODE_CHRONO) begin
      case (it.kind)
        KIND_COUNT: begin
          low = timer[15:0];
          top = timer[23:16];
          // top byte sticks once saturated
          if (low == 16'hFFFF && top != TOP_SAT) top = top + 8'd1;
          low = low + 16'd1;
          timer = {top, low};
        end
        KIND_TICK: begin
          if (countdown != 8'd0) countdown = countdown - 8'd1;
          if (settling && countdown == 8'd0) begin
            lvl = ~it.pin;
            settling = 1'b0;
            if (lvl == held_level) begin
              // spurious change: hand the captured time back to the timer
              timer = timer + stamp;
            end else begin
              held_level = lvl;
              owe_byte(change_hdr, 1'b0);
              owe_byte({7'd0, held_level}, 1'b0);
              owe_byte(stamp[23:16], 1'b0);
              owe_byte(stamp[15:8], 1'b0);
              owe_byte(stamp[7:0], 1'b1);
            end
          end
        end
        KIND_PIN: begin
          if (!settling) begin
            if (awaiting_first) begin
              timer = '0;
              awaiting_first = 1'b0;
            end
            stamp = timer;
            timer = '0;
            countdown = settle_ticks;
            settling = 1'b1;
          end
        end
        KIND_SERIAL: begin
          if (it.rx == status_cmd) begin
            owe_byte(status_rep, 1'b0);
            owe_byte({7'd0, held_level}, 1'b1);
          end
        end
        default: ;
      endcase
    end else begin
      case (it.kind)
        KIND_TICK: begin
          owe_byte(pulses, 1'b1);
          pulses = '0;
        end
        KIND_SERIAL: begin
          if (it.rx == scan_cmd) owe_byte(scan_cmd, 1'b1);
        end
        KIND_ENC: pulses = it.up ? pulses + 8'd1 : pulses - 8'd1;
        default: ;
      endcase
    end
  endfunction

  // Input driver: hold an item until accepted, then advance or insert a gap
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left != 0) begin
        s_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (events_to_send.size() != 0) begin
        next_event = events_to_send.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= next_event.kind;
        s_tdata  <= {6'd0, next_event.up, next_event.rx, next_event.pin};
        if (!calm && $urandom_range(99) < gap_pct) gap_left <= $urandom_range(16, 1);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output back-pressure in bursts
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(99) < stall_pct) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(15, 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Predict on every accepted item, check every accepted byte
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        compute_tx_bytes({s_tuser, s_tdata[0], s_tdata[8:1], s_tdata[9]});
      if (m_tvalid && m_tready) begin
        if (tx_bytes_due.size() == 0) begin
          $error("tx_byte: none expected, got %0h (last %0b)", m_tdata, m_tlast);
          err_count++;
        end else begin
          want = tx_bytes_due.pop_front();
          if (m_tdata !== want.data) begin
            $error("tx_byte: expected %0h, got %0h", want.data, m_tdata);
            err_count++;
          end
          if (m_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, m_tlast);
            err_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic queue_item(input logic [2:0] kind, input logic pin, input logic [7:0] rx,
                            input logic up);
    events_to_send.push_back({kind, pin, rx, up});
  endtask

  task automatic queue_kind(input logic [2:0] kind);
    queue_item(kind, 1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // Wait for the block to drain, then let any late work finish
  task automatic settle();
    do @(negedge clk);
    while (events_to_send.size() != 0 || s_tvalid || tx_bytes_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_MODE:       sel_mode     = val[0];
      REG_DEBOUNCE:   settle_ticks = val;
      REG_STATUS_CMD: status_cmd   = val;
      REG_STATUS_REP: status_rep   = val;
      REG_HEADER:     change_hdr   = val;
      REG_SCAN_CMD:   scan_cmd     = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic md, input logic [7:0] deb, input logic [7:0] scmd,
                              input logic [7:0] srep, input logic [7:0] hdr,
                              input logic [7:0] scan);
    write_reg(REG_MODE, {7'd0, md});
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_STATUS_CMD, scmd);
    write_reg(REG_STATUS_REP, srep);
    write_reg(REG_HEADER, hdr);
    write_reg(REG_SCAN_CMD, scan);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 15;
      default: return 50;
    endcase
  endfunction

  // Count ticks, a pin change, then the full debounce countdown with random pin levels
  task automatic chrono_burst();
    int n;
    repeat ($urandom_range(5)) queue_kind(KIND_COUNT);
    queue_kind(KIND_PIN);
    if ($urandom_range(3) == 0) queue_kind(KIND_PIN);
    n = (settle_ticks == 8'd0) ? 1 : settle_ticks;
    repeat (n) begin
      if ($urandom_range(2) == 0) queue_kind(KIND_COUNT);
      queue_kind(KIND_TICK);
    end
    if ($urandom_range(2) == 0)
      queue_item(KIND_SERIAL, 1'($urandom_range(1)), status_cmd, 1'($urandom_range(1)));
    if ($urandom_range(5) == 0) queue_kind(3'($urandom_range(7)));
  endtask

  // A few encoder edges leaning one way, then a report
  task automatic encoder_burst();
    int   n;
    logic lean;
    n = $urandom_range(6);
    lean = 1'($urandom_range(1));
    repeat (n)
      queue_item(KIND_ENC, 1'($urandom_range(1)), 8'($urandom_range(255)),
                 ($urandom_range(15) == 0) ? ~lean : lean);
    queue_kind(KIND_TICK);
    if ($urandom_range(2) == 0)
      queue_item(KIND_SERIAL, 1'($urandom_range(1)), scan_cmd, 1'($urandom_range(1)));
    if ($urandom_range(5) == 0) queue_kind(3'($urandom_range(7)));
  endtask

  initial begin
    int  phase;
    logic first_mode;
    reset_predictor();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset defaults, encoder mode
    gap_pct   = 30;
    stall_pct = 30;
    queue_kind(KIND_TICK);
    queue_item(KIND_ENC, 1'b0, 8'h00, 1'b1);
    queue_item(KIND_ENC, 1'b1, 8'hFF, 1'b1);
    queue_item(KIND_ENC, 1'b0, 8'h00, 1'b0);
    queue_kind(KIND_TICK);
    queue_item(KIND_SERIAL, 1'b1, RST_SCAN_CMD, 1'b0);
    queue_item(KIND_SERIAL, 1'b0, RST_STATUS_CMD, 1'b1);
    queue_kind(KIND_COUNT);
    queue_kind(KIND_PIN);
    queue_kind(3'd5);

    // Chronometer: first change stamps zero, ignored repeat, real and spurious changes
    settle();
    program_regs(MODE_CHRONO, 8'd1, 8'h00, 8'hFF, 8'h00, 8'hFF);
    queue_item(KIND_SERIAL, 1'b0, 8'h00, 1'b0);
    repeat (3) queue_kind(KIND_COUNT);
    queue_kind(KIND_PIN);
    queue_kind(KIND_PIN);
    repeat (2) queue_kind(KIND_COUNT);
    queue_item(KIND_TICK, 1'b0, 8'hFF, 1'b1);
    repeat (4) queue_kind(KIND_COUNT);
    queue_kind(KIND_PIN);
    queue_item(KIND_TICK, 1'b0, 8'h00, 1'b0);
    queue_kind(KIND_ENC);
    queue_item(KIND_SERIAL, 1'b1, 8'hFF, 1'b1);
    queue_kind(3'd6);
    queue_item(KIND_SERIAL, 1'b1, 8'h00, 1'b0);

    // Zero countdown start evaluates on the next tick
    settle();
    program_regs(MODE_CHRONO, 8'd0, 8'hFF, 8'h00, 8'hFF, 8'h00);
    queue_kind(KIND_PIN);
    queue_item(KIND_TICK, 1'b1, 8'h55, 1'b0);
    queue_item(KIND_SERIAL, 1'b0, 8'hFF, 1'b0);
    queue_item(KIND_SERIAL, 1'b0, 8'h00, 1'b1);
    queue_kind(3'd7);

    // Drive the pulse count past its signed range, then report
    settle();
    gap_pct   = 0;
    stall_pct = 0;
    program_regs(MODE_ENCODER, RST_DEBOUNCE, RST_STATUS_CMD, RST_STATUS_REP, RST_HEADER,
                 RST_SCAN_CMD);
    repeat (130) queue_item(KIND_ENC, 1'b0, 8'h00, 1'b1);
    queue_kind(KIND_TICK);
    queue_item(KIND_SERIAL, 1'b1, scan_cmd, 1'b1);

    first_mode = 1'($urandom_range(1));
    for (phase = 0; phase < 8; phase++) begin
      settle();
      calm      = (phase == 7);
      gap_pct   = pick_pct();
      stall_pct = pick_pct();
      program_regs(first_mode ^ phase[0],
                   8'(($urandom_range(7) == 0) ? $urandom_range(20, 7) : $urandom_range(4, 1)),
                   pick_byte(), pick_byte(), pick_byte(), pick_byte());
      while (events_to_send.size() < 22) begin
        if (sel_mode == MODE_CHRONO) chrono_burst();
        else encoder_burst();
      end
    end

    settle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/dec_pkg.sv
rtl/dec_core.sv
rtl/dec_frame_fifo.sv
rtl/debounced_event_chronometer.sv
tb/tb_debounced_event_chronometer.sv
